// ----- rtl/fre_pkg.sv -----
// Shared types, constants and helper functions for the fire row engine.
package fre_pkg;

	// Default sizes, handed down from the top level
	localparam int ROW_PIXELS_DEF   = 256;
	localparam int RANDOM_DEPTH_DEF = 256;
	localparam int ZONE_ROWS_DEF    = 128;

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int ADV_W   = 8;
	localparam int COL_W   = 5;
	localparam int ROFF_W  = 7;
	localparam int PLANE_W = 8;
	localparam int THR_W   = 9;
	localparam int RND_W   = 8;
	localparam int PIX_W   = 4;
	localparam int LCG_W   = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// Random table generator
	localparam logic [LCG_W-1:0] LCG_SEED = 16'h1234;
	localparam logic [RND_W-1:0] LCG_MUL  = 8'd251;
	localparam logic [RND_W-1:0] LCG_INC  = 8'd73;

	// Register map (word index taken from paddr[2])
	localparam logic REG_DECAY_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = 9'd64;

	// Item opcodes
	localparam logic [OP_W-1:0] OP_SEED = 2'd0;
	localparam logic [OP_W-1:0] OP_NEXT = 2'd1;
	localparam logic [OP_W-1:0] OP_ADV  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic fill;        // write one random table entry
		logic start_seed;  // item accepted: seed bottom row
		logic start_next;  // item accepted: build next row
		logic start_adv;   // item accepted: advance random index
		logic issue;       // start one pixel down the pipeline
		logic seed;        // pixel pipeline runs in seed mode
		logic adv;         // one reduction step of the index sum
		logic flip;        // swap the row stores
		logic emit;        // send groups out
	} fre_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fill_last;   // last table entry is being written
		logic issue_last;  // last pixel of the row is being issued
		logic pipe_empty;  // no pixel in flight
		logic adv_done;    // index sum is reduced below the table depth
		logic emit_done;   // final group taken
	} fre_sts_t;

	// r mod 5 for a byte: quotient by reciprocal 205/1024, exact for 8 bits
	function automatic logic [2:0] mod5(input logic [RND_W-1:0] r);
		logic [15:0] prod;
		logic [7:0]  quo;
		logic [7:0]  rem;
		prod = 16'(r) * 16'd205;
		quo  = 8'(prod >> 10);
		rem  = r - 8'(quo * 8'd5);
		return rem[2:0];
	endfunction

endpackage

// ----- rtl/fre_ctrl.sv -----
// Controller state machine of the fire row engine.
module fre_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [fre_pkg::OP_W-1:0] opcode,
	output logic                    in_stall,
	input  fre_pkg::fre_sts_t       sts,
	output fre_pkg::fre_cmd_t       cmd
);
	import fre_pkg::*;

	typedef enum logic [5:0] {
		ST_FILL  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_COMP  = 6'b000100,
		ST_DRAIN = 6'b001000,
		ST_ADV   = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   seed_q, seed_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			seed_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			seed_q  <= seed_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		seed_d  = seed_q;
		cmd     = '0;
		case (state_q)
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (opcode == OP_SEED) begin
						cmd.start_seed = 1'b1;
						seed_d         = 1'b1;
						state_d        = ST_COMP;
					end else if (opcode == OP_NEXT) begin
						cmd.start_next = 1'b1;
						seed_d         = 1'b0;
						state_d        = ST_COMP;
					end else if (opcode == OP_ADV) begin
						cmd.start_adv = 1'b1;
						state_d       = ST_ADV;
					end
				end
			end
			ST_COMP: begin
				cmd.issue = 1'b1;
				cmd.seed  = seed_q;
				if (sts.issue_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					cmd.flip = !seed_q;
					state_d  = ST_EMIT;
				end
			end
			ST_ADV: begin
				cmd.adv = 1'b1;
				if (sts.adv_done) state_d = ST_IDLE;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (sts.emit_done) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/fre_datapath.sv -----
// Datapath: random table, row stores, pixel pipeline and group output buffer.
module fre_datapath #(
	parameter int ROW_PIXELS   = fre_pkg::ROW_PIXELS_DEF,
	parameter int RANDOM_DEPTH = fre_pkg::RANDOM_DEPTH_DEF,
	parameter int ZONE_ROWS    = fre_pkg::ZONE_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fre_pkg::fre_cmd_t             cmd,
	output fre_pkg::fre_sts_t             sts,
	input  logic [fre_pkg::THR_W-1:0]     thr,
	input  logic [fre_pkg::ADV_W-1:0]     index_advance,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fre_pkg::COL_W-1:0]     column,
	output logic [fre_pkg::ROFF_W-1:0]    row_offset,
	output logic [fre_pkg::PLANE_W-1:0]   plane3,
	output logic [fre_pkg::PLANE_W-1:0]   plane2,
	output logic [fre_pkg::PLANE_W-1:0]   plane1,
	output logic [fre_pkg::PLANE_W-1:0]   plane0,
	output logic                          last
);
	import fre_pkg::*;

	localparam int X_W    = $clog2(ROW_PIXELS);
	localparam int SX_W   = X_W + 2;
	localparam int GROUPS = ROW_PIXELS / 8;
	localparam int G_W    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GC_W   = $clog2(GROUPS + 1);
	localparam int RI_W   = $clog2(RANDOM_DEPTH);
	localparam int AC_W   = $clog2(RANDOM_DEPTH + 256);
	localparam int OF_W   = (ZONE_ROWS > 1) ? $clog2(ZONE_ROWS) : 1;
	localparam int RS_DEPTH = 2 * (2 ** X_W);
	localparam int GW_W   = 4 * PLANE_W;

	// ---------------- random table ----------------
	logic [RND_W-1:0] rmem [RANDOM_DEPTH];
	logic [LCG_W-1:0] lcg_q, lcg_nx;
	logic [RI_W-1:0]  fill_q;
	logic [RI_W-1:0]  ri_q, ri1, ri2;
	logic [AC_W-1:0]  acc_q;
	logic [RND_W-1:0] rd0_q, rd1_q;

	assign lcg_nx = 16'(24'(lcg_q) * 24'(LCG_MUL)) + 16'(LCG_INC);

	// table fill after reset, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q  <= LCG_SEED;
			fill_q <= '0;
		end else if (cmd.fill) begin
			lcg_q  <= lcg_nx;
			fill_q <= fill_q + 1'b1;
		end
	end

	// two read ports: r1 at the index, r2 at the index plus one
	always_ff @(posedge clk) begin
		if (cmd.fill) rmem[fill_q] <= lcg_nx[LCG_W-1 -: RND_W];
		rd0_q <= rmem[ri_q];
		rd1_q <= rmem[ri1];
	end

	assign ri1 = (ri_q == RI_W'(RANDOM_DEPTH - 1)) ? '0 : ri_q + 1'b1;
	assign ri2 = (ri1 == RI_W'(RANDOM_DEPTH - 1)) ? '0 : ri1 + 1'b1;

	// random index: step per pixel, or reduce index plus advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ri_q <= '0;
		end else if (cmd.issue) begin
			ri_q <= cmd.seed ? ri1 : ri2;
		end else if (cmd.adv && (acc_q < AC_W'(RANDOM_DEPTH))) begin
			ri_q <= acc_q[RI_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_adv) begin
			acc_q <= AC_W'(ri_q) + AC_W'(index_advance);
		end else if (cmd.adv && (acc_q >= AC_W'(RANDOM_DEPTH))) begin
			acc_q <= acc_q - AC_W'(RANDOM_DEPTH);
		end
	end

	// ---------------- row control ----------------
	logic [X_W-1:0]  x_q;
	logic [OF_W-1:0] off_q;
	logic            sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			off_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (cmd.start_seed || cmd.start_next) x_q <= '0;
			else if (cmd.issue) x_q <= x_q + 1'b1;
			if (cmd.start_seed) off_q <= '0;
			else if (cmd.start_next)
				off_q <= (off_q == OF_W'(ZONE_ROWS - 1)) ? '0 : off_q + 1'b1;
			if (cmd.flip) sel_q <= !sel_q;
		end
	end

	// ---------------- pixel pipeline ----------------
	logic              v_s1, v_s2;
	logic              seed_s1, seed_s2;
	logic [X_W-1:0]    x_s1, x_s2;
	logic              dec_s2;
	logic [PIX_W-1:0]  sv_s2;
	logic [2:0]        shift;
	logic [SX_W-1:0]   sx_t;
	logic [X_W-1:0]    sx;
	logic              dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		seed_s1 <= cmd.seed;
		x_s1    <= x_q;
		seed_s2 <= seed_s1;
		x_s2    <= x_s1;
		dec_s2  <= dec;
		sv_s2   <= rd0_q[PIX_W-1:0];
	end

	// stage 1: source position from r1, decay from r2
	always_comb begin
		shift = mod5(rd0_q);
		sx_t  = SX_W'(x_s1) + SX_W'(shift) + SX_W'(ROW_PIXELS - 2);
		if (sx_t >= SX_W'(2 * ROW_PIXELS)) sx = X_W'(sx_t - SX_W'(2 * ROW_PIXELS));
		else if (sx_t >= SX_W'(ROW_PIXELS)) sx = X_W'(sx_t - SX_W'(ROW_PIXELS));
		else sx = X_W'(sx_t);
		dec = ({1'b0, rd1_q} < thr);
	end

	// row stores, both banks in one array, bank in the top address bit
	logic [PIX_W-1:0] rs_mem [RS_DEPTH];
	logic [PIX_W-1:0] rs_rd_q;
	logic [PIX_W-1:0] val;
	logic             wbank;

	always_ff @(posedge clk) begin
		if (v_s2) rs_mem[{wbank, x_s2}] <= val;
		rs_rd_q <= rs_mem[{sel_q, sx}];
	end

	// stage 2: seeded value, or source minus decay floored at zero
	always_comb begin
		wbank = seed_s2 ? sel_q : !sel_q;
		if (seed_s2) val = sv_s2;
		else if (rs_rd_q > PIX_W'(dec_s2)) val = rs_rd_q - PIX_W'(dec_s2);
		else val = '0;
	end

	// bitplane assembly, pixel 0 of a group ends up in bit 7
	logic [PLANE_W-1:0] pl_q  [PIX_W];
	logic [PLANE_W-1:0] pl_nx [PIX_W];
	logic               gwr;
	logic [GW_W-1:0]    gword;

	always_comb begin
		for (int k = 0; k < PIX_W; k++) begin
			pl_nx[k] = {pl_q[k][PLANE_W-2:0], val[k]};
		end
		gword = {pl_nx[3], pl_nx[2], pl_nx[1], pl_nx[0]};
		gwr   = v_s2 && (x_s2[2:0] == 3'b111);
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			for (int k = 0; k < PIX_W; k++) pl_q[k] <= pl_nx[k];
		end
	end

	// ---------------- group buffer and output ----------------
	logic [GW_W-1:0]  gbuf [GROUPS];
	logic [GW_W-1:0]  gq_q;
	logic [GC_W-1:0]  eg_q;
	logic             ov_q;
	logic             erd;
	logic [COL_W-1:0] col_q;
	logic             last_q;

	assign erd = cmd.emit && (eg_q != GC_W'(GROUPS)) && (!ov_q || !out_stall);

	always_ff @(posedge clk) begin
		if (gwr) gbuf[G_W'(x_s2 >> 3)] <= gword;
		if (erd) begin
			gq_q   <= gbuf[eg_q[G_W-1:0]];
			col_q  <= COL_W'(eg_q);
			last_q <= (eg_q == GC_W'(GROUPS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eg_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.start_seed || cmd.start_next) eg_q <= '0;
			else if (erd) eg_q <= eg_q + 1'b1;
			if (erd) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	assign out_valid  = ov_q;
	assign column     = col_q;
	assign row_offset = ROFF_W'(off_q);
	assign plane3     = gq_q[4*PLANE_W-1 -: PLANE_W];
	assign plane2     = gq_q[3*PLANE_W-1 -: PLANE_W];
	assign plane1     = gq_q[2*PLANE_W-1 -: PLANE_W];
	assign plane0     = gq_q[PLANE_W-1:0];
	assign last       = last_q;

	// status
	always_comb begin
		sts            = '0;
		sts.fill_last  = (fill_q == RI_W'(RANDOM_DEPTH - 1));
		sts.issue_last = (x_q == X_W'(ROW_PIXELS - 1));
		sts.pipe_empty = !v_s1 && !v_s2;
		sts.adv_done   = (acc_q < AC_W'(RANDOM_DEPTH));
		sts.emit_done  = (eg_q == GC_W'(GROUPS)) && (!ov_q || !out_stall);
	end

endmodule

// ----- rtl/fire_effect_row_engine.sv -----
// Fire row engine: ROW_PIXELS pixels/row, 1 pixel/cycle; groups follow once the row is done.
// Opcodes 0/1 build a row through the single row-store read port, then send it out as
// ROW_PIXELS/8 groups; groups leave one per cycle while out_stall is low.
// Opcode 2 reduces the index sum one subtract per cycle; opcode 3 is accepted and ignored.
// Reset: async, active low; the random table then fills all RANDOM_DEPTH entries with
// in_stall high. Row stores hold no reset value.
module fire_effect_row_engine #(
	parameter int ROW_PIXELS   = fre_pkg::ROW_PIXELS_DEF,
	parameter int RANDOM_DEPTH = fre_pkg::RANDOM_DEPTH_DEF,
	parameter int ZONE_ROWS    = fre_pkg::ZONE_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fre_pkg::OP_W-1:0]      opcode,
	input  logic [fre_pkg::ADV_W-1:0]     index_advance,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [fre_pkg::COL_W-1:0]     column,
	output logic [fre_pkg::ROFF_W-1:0]    row_offset,
	output logic [fre_pkg::PLANE_W-1:0]   plane3,
	output logic [fre_pkg::PLANE_W-1:0]   plane2,
	output logic [fre_pkg::PLANE_W-1:0]   plane1,
	output logic [fre_pkg::PLANE_W-1:0]   plane0,
	output logic                          last,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fre_pkg::APB_AW-1:0]    paddr,
	input  logic [fre_pkg::APB_DW-1:0]    pwdata,
	output logic [fre_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import fre_pkg::*;

	fre_cmd_t         cmd;
	fre_sts_t         sts;
	logic [THR_W-1:0] thr_q;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_DECAY_THRESHOLD)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_DECAY_THRESHOLD) ? APB_DW'(thr_q) : '0;

	fre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fre_datapath #(
		.ROW_PIXELS   (ROW_PIXELS),
		.RANDOM_DEPTH (RANDOM_DEPTH),
		.ZONE_ROWS    (ZONE_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.thr           (thr_q),
		.index_advance (index_advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.column        (column),
		.row_offset    (row_offset),
		.plane3        (plane3),
		.plane2        (plane2),
		.plane1        (plane1),
		.plane0        (plane0),
		.last          (last)
	);

	// results only come out while an item is in progress
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("result shown while idle");

	// a seed item keeps the block busy
	a_seed_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && (opcode == OP_SEED)) |=> in_stall)
		else $error("seed item did not start work");

	// no further result once the final group is taken
	a_last_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> !out_valid)
		else $error("result after final group");

	// groups follow back to back in column order
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=>
		(out_valid && (column == 5'($past(column) + 5'd1))))
		else $error("group order broken");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the fire row engine: seeded and decayed rows over the item ports.
`timescale 1ns / 1ps

module tb;
	import fre_pkg::*;

	localparam int LIMIT_CYCLES = 5000;   // cycles with no handshake before giving up
	localparam int IDLE_CYCLES  = 40;     // settle time once no group is outstanding
	localparam int HOLD_CYCLES  = 700;    // long receiver hold-off
	localparam int LONG_RUN     = 130;    // next-row items in a row, enough to wrap the offset

	localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] THR_ADDR  = {REG_DECAY_THRESHOLD, 2'b00};

	// One emitted 8-pixel group
	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [ROFF_W-1:0]  row_offset;
		logic [PLANE_W-1:0] plane3;
		logic [PLANE_W-1:0] plane2;
		logic [PLANE_W-1:0] plane1;
		logic [PLANE_W-1:0] plane0;
		logic               last;
	} group_t;

	// Fire row predictor plus the queue of groups still due from the block
	class fire_rows;
		bit [PIX_W-1:0] store [2][ROW_PIXELS_DEF];
		bit             sel;
		bit [RND_W-1:0] rnd [RANDOM_DEPTH_DEF];
		int unsigned    rnd_idx;
		int unsigned    offset;
		int unsigned    threshold;
		group_t         groups_due[$];
		int             mismatches;

		function new();
			bit [LCG_W-1:0] s;
			s = LCG_SEED;
			for (int i = 0; i < RANDOM_DEPTH_DEF; i++) begin
				s = s * LCG_W'(LCG_MUL) + LCG_W'(LCG_INC);
				rnd[i] = s[LCG_W-1 -: RND_W];
			end
			sel        = 1'b0;
			rnd_idx    = 0;
			offset     = 0;
			threshold  = THR_RESET;
			mismatches = 0;
		endfunction

		function int unsigned pull_rnd();
			int unsigned v;
			v = rnd[rnd_idx];
			rnd_idx = (rnd_idx + 1) % RANDOM_DEPTH_DEF;
			return v;
		endfunction

		// Split a row into bitplane groups, pixel 0 of a group in bit 7
		function void queue_row(bit src);
			group_t g;
			bit [PIX_W-1:0] c;
			for (int k = 0; k < ROW_PIXELS_DEF / 8; k++) begin
				g = '0;
				for (int b = 0; b < 8; b++) begin
					c = store[src][k * 8 + b];
					g.plane3[7 - b] = c[3];
					g.plane2[7 - b] = c[2];
					g.plane1[7 - b] = c[1];
					g.plane0[7 - b] = c[0];
				end
				g.column     = COL_W'(k);
				g.row_offset = ROFF_W'(offset);
				g.last       = (k == ROW_PIXELS_DEF / 8 - 1);
				groups_due.push_back(g);
			end
		endfunction

		function void note_item(logic [OP_W-1:0] op, logic [ADV_W-1:0] adv);
			int unsigned shift, sx, below, decay;
			case (op)
				OP_SEED: begin
					for (int x = 0; x < ROW_PIXELS_DEF; x++)
						store[sel][x] = PIX_W'(pull_rnd() & 15);
					offset = 0;
					queue_row(sel);
				end
				OP_NEXT: begin
					// shift read first, then the decay byte
					for (int x = 0; x < ROW_PIXELS_DEF; x++) begin
						shift = pull_rnd() % 5;
						sx    = (x + shift + ROW_PIXELS_DEF - 2) % ROW_PIXELS_DEF;
						below = store[sel][sx];
						decay = (pull_rnd() < threshold) ? 1 : 0;
						store[sel ^ 1'b1][x] = (below > decay) ? PIX_W'(below - decay) : '0;
					end
					sel    = sel ^ 1'b1;
					offset = (offset + 1) % ZONE_ROWS_DEF;
					queue_row(sel);
				end
				OP_ADV: rnd_idx = (rnd_idx + adv) % RANDOM_DEPTH_DEF;
				default: ;
			endcase
		endfunction

		function void check_group(group_t got);
			group_t want;
			if (groups_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected group col %0d off %0d", $realtime,
						got.column, got.row_offset);
				return;
			end
			want = groups_due.pop_front();
			if (got.column !== want.column || got.row_offset !== want.row_offset ||
			    got.plane3 !== want.plane3 || got.plane2 !== want.plane2 ||
			    got.plane1 !== want.plane1 || got.plane0 !== want.plane0 ||
			    got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: group mismatch exp col %0d off %0d p %h %h %h %h last %b",
						$realtime, want.column, want.row_offset, want.plane3, want.plane2,
						want.plane1, want.plane0, want.last,
						"\n          got col %0d off %0d p %h %h %h %h last %b",
						got.column, got.row_offset, got.plane3, got.plane2,
						got.plane1, got.plane0, got.last);
			end
		endfunction

		function int pending();
			return groups_due.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode = '0;
	logic [ADV_W-1:0]     index_advance = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [COL_W-1:0]     column;
	logic [ROFF_W-1:0]    row_offset;
	logic [PLANE_W-1:0]   plane3, plane2, plane1, plane0;
	logic                 last;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [APB_AW-1:0]    paddr = '0;
	logic [APB_DW-1:0]    pwdata = '0;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	fire_rows rows = new();
	bit       sender_eager = 1'b0;
	bit       hold_req = 1'b0;
	int       quiet_cycles = 0;

	fire_effect_row_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .index_advance(index_advance),
		.out_valid(out_valid), .out_stall(out_stall),
		.column(column), .row_offset(row_offset),
		.plane3(plane3), .plane2(plane2), .plane1(plane1), .plane0(plane0),
		.last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [OP_W-1:0] pick_mixed_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return OP_SEED;
		if (r < 70) return OP_NEXT;
		if (r < 90) return OP_ADV;
		return OP_UNUSED;
	endfunction

	// Called at a falling edge; returns at a falling edge
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ADV_W-1:0] adv);
		int gap;
		in_valid      <= 1'b1;
		opcode        <= op;
		index_advance <= adv;
		do @(posedge clk); while (in_stall);
		rows.note_item(op, adv);
		@(negedge clk);
		gap = sender_eager ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drain every outstanding group, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (rows.pending() > 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] value);
		logic [APB_DW-1:0] word;
		word = $urandom;
		word[THR_W-1:0] = value;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= THR_ADDR;
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rows.threshold = value;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stimulus
	initial begin
		int nexts;
		logic [OP_W-1:0] op;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// directed: seed first, every opcode, advance extremes, default threshold
		send_item(OP_SEED, 8'hFF);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_NEXT, 8'hFF);
		send_item(OP_ADV, 8'h00);
		send_item(OP_NEXT, 8'h5A);
		send_item(OP_ADV, 8'hFF);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_UNUSED, 8'h55);
		send_item(OP_ADV, 8'hAA);
		send_item(OP_ADV, 8'h55);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_SEED, 8'h00);
		send_item(OP_NEXT, 8'h00);
		wait_idle();

		// no decay at all
		write_threshold(9'd0);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_SEED, 8'h00);
		wait_idle();

		// every byte decays, at 256 and at the top of the field
		write_threshold(9'd256);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_NEXT, 8'h00);
		wait_idle();
		write_threshold(9'd511);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_NEXT, 8'h00);
		send_item(OP_UNUSED, 8'hFF);
		wait_idle();

		// long climb without reseeding so the row offset wraps; low decay keeps some fire
		write_threshold(THR_W'($urandom_range(0, 24)));
		sender_eager = 1'b1;
		send_item(OP_SEED, ADV_W'($urandom));
		sender_eager = 1'b0;
		nexts = 0;
		while (nexts < LONG_RUN) begin
			if ($urandom_range(0, 99) < 90) begin
				send_item(OP_NEXT, ADV_W'($urandom));
				nexts++;
			end else begin
				send_item(($urandom_range(0, 1) != 0) ? OP_ADV : OP_UNUSED,
					ADV_W'($urandom));
			end
			if (nexts == 40) sender_eager = 1'b1;
			if (nexts == 60) sender_eager = 1'b0;
		end
		wait_idle();

		// mixed items, any threshold, with the receiver holding off early on;
		// the row stores are already seeded, so next-row items are safe
		write_threshold(THR_W'($urandom_range(0, 511)));
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++) begin
			op = pick_mixed_op();
			send_item(op, ADV_W'($urandom));
		end
		wait_idle();

		write_threshold(THR_W'($urandom_range(48, 80)));
		for (int i = 0; i < 12; i++) begin
			op = pick_mixed_op();
			send_item(op, ADV_W'($urandom));
		end
		wait_idle();

		if (rows.mismatches == 0 && rows.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Receiver: stall runs of random length, one long hold when asked
	initial begin
		int n;
		int r;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall <= 1'b0;
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 40);
				end else begin
					out_stall <= 1'b1;
					if (r < 90) n = $urandom_range(1, 3);
					else if (r < 98) n = $urandom_range(5, 20);
					else n = $urandom_range(40, 80);
				end
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Result check
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			rows.check_group('{column, row_offset, plane3, plane2, plane1, plane0, last});
	end

	// Watchdog on handshake activity
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

endmodule
